// ----- rtl/rmq_pkg.sv -----
// Package: payload types, widths and shared constants for the matrix-to-quaternion pipeline
package rmq_pkg;

    localparam int WordBits = 16;
    localparam int FracBits = 14;
    localparam int RadBits  = WordBits + 3;             // radicand, signed
    localparam int SqInBits = 2 * ((RadBits + FracBits + 1) / 2); // even width of R<<F
    localparam int SqrtBits = SqInBits / 2;             // width of S
    localparam int DiffBits = WordBits + 1;             // pair sum or difference
    localparam int NumBits  = DiffBits - 1 + FracBits + 1; // magnitude<<F plus S
    localparam int DenBits  = SqrtBits + 1;             // 2*S
    localparam int QuoBits  = NumBits;
    localparam int SqSteps  = SqrtBits;
    localparam int DivSteps = NumBits;

    localparam logic [1:0] CaseTrace = 2'd0;
    localparam logic [1:0] CaseRootX = 2'd1;
    localparam logic [1:0] CaseRootY = 2'd2;
    localparam logic [1:0] CaseRootZ = 2'd3;

    typedef struct packed {
        logic signed [WordBits-1:0] e00;
        logic signed [WordBits-1:0] e01;
        logic signed [WordBits-1:0] e02;
        logic signed [WordBits-1:0] e10;
        logic signed [WordBits-1:0] e11;
        logic signed [WordBits-1:0] e12;
        logic signed [WordBits-1:0] e20;
        logic signed [WordBits-1:0] e21;
        logic signed [WordBits-1:0] e22;
    } t_req;

    typedef struct packed {
        logic signed [WordBits-1:0] qw;
        logic signed [WordBits-1:0] qx;
        logic signed [WordBits-1:0] qy;
        logic signed [WordBits-1:0] qz;
        logic [1:0]                 root_case;
        logic                       invalid;
    } t_rsp;

    // Sideband carried alongside the divide lanes
    typedef struct packed {
        logic [1:0]                 root_case;
        logic                       invalid;
        logic signed [WordBits-1:0] root_q;
    } t_side;

    function automatic logic signed [WordBits-1:0] sat_mag(
        input logic neg, input logic [QuoBits-1:0] mag);
        logic [QuoBits:0] lim;
        begin
            lim = neg ? ({{(QuoBits+1-WordBits){1'b0}}, 1'b1, {(WordBits-1){1'b0}}})
                      : ({{(QuoBits+1-WordBits){1'b0}}, 1'b0, {(WordBits-1){1'b1}}});
            if ({1'b0, mag} > lim) begin
                mag = lim[QuoBits-1:0];
            end
            sat_mag = neg ? WordBits'(-$signed({1'b0, mag})) : WordBits'(mag);
        end
    endfunction

endpackage

// ----- rtl/rmq_div_lane.sv -----
// Divider lane: pipelined restoring division of |d|<<F + S by 2S, one quotient bit per stage
module rmq_div_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [rmq_pkg::NumBits-1:0]          i_num,
    input  logic [rmq_pkg::DenBits-1:0]          i_den,
    input  logic                                 i_neg,
    output logic signed [rmq_pkg::WordBits-1:0]  o_q
);
    import rmq_pkg::*;

    logic [NumBits-1:0] r_num [DivSteps+1];
    logic [DenBits:0]   r_rem [DivSteps+1];
    logic [DenBits-1:0] r_den [DivSteps+1];
    logic               r_neg [DivSteps+1];
    logic signed [WordBits-1:0] r_q;

    always_comb begin
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_neg[0] = i_neg;
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_step
        logic [DenBits:0] n_rem;
        logic [DenBits:0] n_try;
        logic [NumBits-1:0] n_num;
        always_comb begin
            n_rem = {r_rem[k][DenBits-1:0], r_num[k][NumBits-1]};
            n_try = n_rem - {1'b0, r_den[k]};
            n_num = {r_num[k][NumBits-2:0], ~n_try[DenBits]};
            if (!n_try[DenBits]) begin
                n_rem = n_try;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1] <= n_num;
                r_rem[k+1] <= n_rem;
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= sat_mag(r_neg[DivSteps], r_num[DivSteps]);
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/rotation_matrix_to_quaternion_top.sv -----
// Top level: matrix-to-quaternion pipeline with square root and three divider lanes
// Words are Q2.14; one request per cycle unless a blocked output stalls the pipeline.
// Throughput is one request per cycle; latency is set by the square-root and divider
// stage chains, and a blocked output stalls every stage at once on a single enable.
// Reset: i_rst_n synchronous active low clears all valid bits; payload is not reset.
module rotation_matrix_to_quaternion_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rmq_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output rmq_pkg::t_rsp   o_rsp
);
    import rmq_pkg::*;

    localparam int Depth = 3 + SqSteps + DivSteps + 1;

    logic             en;
    logic [Depth-1:0] r_vld;
    logic             r_ovld;
    t_rsp             r_orsp;

    // Skid output: pipeline advances when its tail is empty or output can take it
    assign en      = !r_vld[Depth-1] || !r_ovld || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[Depth-2:0], i_valid};
            end
            if (en && r_vld[Depth-1]) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Stage 1: register request, trace and diagonal selection
    t_req r1_m;
    logic signed [RadBits-1:0] r1_tr;
    logic [1:0] r1_case;
    logic signed [RadBits-1:0] n1_tr;
    logic [1:0] n1_case;
    always_comb begin
        n1_tr = RadBits'(i_req.e00) + RadBits'(i_req.e11) + RadBits'(i_req.e22);
        if (n1_tr > 0) begin
            n1_case = CaseTrace;
        end else if (i_req.e00 > i_req.e11 && i_req.e00 > i_req.e22) begin
            n1_case = CaseRootX;
        end else if (i_req.e11 > i_req.e22) begin
            n1_case = CaseRootY;
        end else begin
            n1_case = CaseRootZ;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_m    <= i_req;
            r1_tr   <= n1_tr;
            r1_case <= n1_case;
        end
    end

    // Stage 2: radicand and pair terms
    localparam logic signed [RadBits-1:0] OneFix = RadBits'(1) <<< FracBits;
    logic signed [RadBits-1:0] n2_rad;
    logic signed [DiffBits-1:0] n2_d [3];
    always_comb begin
        case (r1_case)
            CaseTrace: begin
                n2_rad = r1_tr + OneFix;
                n2_d[0] = DiffBits'(r1_m.e12) - DiffBits'(r1_m.e21);
                n2_d[1] = DiffBits'(r1_m.e20) - DiffBits'(r1_m.e02);
                n2_d[2] = DiffBits'(r1_m.e01) - DiffBits'(r1_m.e10);
            end
            CaseRootX: begin
                n2_rad = OneFix + RadBits'(r1_m.e00) - (RadBits'(r1_m.e11) + RadBits'(r1_m.e22));
                n2_d[0] = DiffBits'(r1_m.e12) - DiffBits'(r1_m.e21);
                n2_d[1] = DiffBits'(r1_m.e01) + DiffBits'(r1_m.e10);
                n2_d[2] = DiffBits'(r1_m.e02) + DiffBits'(r1_m.e20);
            end
            CaseRootY: begin
                n2_rad = OneFix + RadBits'(r1_m.e11) - (RadBits'(r1_m.e22) + RadBits'(r1_m.e00));
                n2_d[0] = DiffBits'(r1_m.e20) - DiffBits'(r1_m.e02);
                n2_d[1] = DiffBits'(r1_m.e10) + DiffBits'(r1_m.e01);
                n2_d[2] = DiffBits'(r1_m.e12) + DiffBits'(r1_m.e21);
            end
            default: begin
                n2_rad = OneFix + RadBits'(r1_m.e22) - (RadBits'(r1_m.e00) + RadBits'(r1_m.e11));
                n2_d[0] = DiffBits'(r1_m.e01) - DiffBits'(r1_m.e10);
                n2_d[1] = DiffBits'(r1_m.e20) + DiffBits'(r1_m.e02);
                n2_d[2] = DiffBits'(r1_m.e21) + DiffBits'(r1_m.e12);
            end
        endcase
    end

    logic [SqInBits-1:0] r2_rad;
    logic               r2_inv;
    logic [1:0]         r2_case;
    logic signed [DiffBits-1:0] r2_d [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_inv  <= (n2_rad <= 0);
            r2_rad  <= (n2_rad <= 0) ? '0
                     : SqInBits'({n2_rad[RadBits-2:0], {FracBits{1'b0}}});
            r2_case <= r1_case;
            r2_d    <= n2_d;
        end
    end

    // Square root stages: one result bit per stage
    logic [SqInBits-1:0] r_sv [SqSteps+1];
    logic [SqrtBits+1:0] r_sr [SqSteps+1];
    logic [SqrtBits-1:0] r_sq [SqSteps+1];
    logic               r_sinv [SqSteps+1];
    logic [1:0]         r_scase [SqSteps+1];
    logic signed [DiffBits-1:0] r_sd [SqSteps+1][3];
    always_comb begin
        r_sv[0]    = r2_rad;
        r_sr[0]    = '0;
        r_sq[0]    = '0;
        r_sinv[0]  = r2_inv;
        r_scase[0] = r2_case;
        r_sd[0]    = r2_d;
    end

    for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
        logic [SqrtBits+1:0] n_rem;
        logic [SqrtBits+1:0] n_try;
        logic [SqrtBits-1:0] n_q;
        always_comb begin
            n_rem = {r_sr[k][SqrtBits-1:0], r_sv[k][SqInBits-1:SqInBits-2]};
            n_try = n_rem - {r_sq[k], 2'b01};
            n_q   = {r_sq[k][SqrtBits-2:0], ~n_try[SqrtBits+1]};
            if (!n_try[SqrtBits+1]) begin
                n_rem = n_try;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sv[k+1]    <= {r_sv[k][SqInBits-3:0], 2'b00};
                r_sr[k+1]    <= n_rem;
                r_sq[k+1]    <= n_q;
                r_sinv[k+1]  <= r_sinv[k];
                r_scase[k+1] <= r_scase[k];
                r_sd[k+1]    <= r_sd[k];
            end
        end
    end

    // Stage after root: root component, numerators and divisor
    logic [SqrtBits-1:0] s_fix;
    logic [SqrtBits:0]   s_half;
    t_side               n3_side;
    logic [NumBits-1:0]  n3_num [3];
    logic                n3_neg [3];
    always_comb begin
        s_fix  = (r_sq[SqSteps] == '0) ? SqrtBits'(1) : r_sq[SqSteps];
        s_half = ({1'b0, s_fix} + 1'b1) >> 1;
        n3_side.root_case = r_scase[SqSteps];
        n3_side.invalid   = r_sinv[SqSteps];
        n3_side.root_q    = sat_mag(1'b0, QuoBits'(s_half));
        for (int j = 0; j < 3; j++) begin
            n3_neg[j] = r_sd[SqSteps][j][DiffBits-1];
            n3_num[j] = NumBits'({(n3_neg[j] ? DiffBits'(-r_sd[SqSteps][j])
                                             : DiffBits'(r_sd[SqSteps][j])),
                                  {FracBits{1'b0}}}) + NumBits'(s_fix);
        end
    end

    logic [NumBits-1:0] r3_num [3];
    logic               r3_neg [3];
    logic [DenBits-1:0] r3_den;
    t_side              r3_side;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num  <= n3_num;
            r3_neg  <= n3_neg;
            r3_den  <= {s_fix, 1'b0};
            r3_side <= n3_side;
        end
    end

    logic signed [WordBits-1:0] lane_q [3];
    for (genvar j = 0; j < 3; j++) begin : g_lane
        rmq_div_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_num   (r3_num[j]),
            .i_den   (r3_den),
            .i_neg   (r3_neg[j]),
            .o_q     (lane_q[j])
        );
    end

    // Match the lane depth: divide steps plus the lane output register
    t_side r_side [DivSteps+2];
    always_comb begin
        r_side[0] = r3_side;
    end
    for (genvar k = 0; k < DivSteps + 1; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // Final assembly into the output register
    t_rsp n_orsp;
    always_comb begin
        n_orsp.root_case = r_side[DivSteps+1].root_case;
        n_orsp.invalid   = r_side[DivSteps+1].invalid;
        case (r_side[DivSteps+1].root_case)
            CaseTrace: begin
                n_orsp.qw = r_side[DivSteps+1].root_q;
                n_orsp.qx = lane_q[0];
                n_orsp.qy = lane_q[1];
                n_orsp.qz = lane_q[2];
            end
            CaseRootX: begin
                n_orsp.qx = r_side[DivSteps+1].root_q;
                n_orsp.qw = lane_q[0];
                n_orsp.qy = lane_q[1];
                n_orsp.qz = lane_q[2];
            end
            CaseRootY: begin
                n_orsp.qy = r_side[DivSteps+1].root_q;
                n_orsp.qw = lane_q[0];
                n_orsp.qx = lane_q[1];
                n_orsp.qz = lane_q[2];
            end
            default: begin
                n_orsp.qz = r_side[DivSteps+1].root_q;
                n_orsp.qw = lane_q[0];
                n_orsp.qx = lane_q[1];
                n_orsp.qy = lane_q[2];
            end
        endcase
        if (r_side[DivSteps+1].invalid) begin
            n_orsp.qw = '0;
            n_orsp.qx = '0;
            n_orsp.qy = '0;
            n_orsp.qz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[Depth-1]) begin
            r_orsp <= n_orsp;
        end
    end

    assign o_valid = r_ovld;
    assign o_rsp   = r_orsp;

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !i_ready |=> r_ovld && $stable(r_orsp))
        else $error("held response lost");
    a_tail_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> r_vld[Depth-1] && r_ovld)
        else $error("pipeline stalled without a blocked tail");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && r_orsp.invalid |-> r_orsp.qw == '0 && r_orsp.qx == '0)
        else $error("invalid response carries data");

endmodule

// ----- test/rotation_matrix_to_quaternion_top_test.sv -----
// Testbench: matrix-to-quaternion pipeline checked against an in-bench predictor
module rotation_matrix_to_quaternion_top_test;
    import rmq_pkg::*;

    localparam int Latency = 52;
    localparam int WatchLimit = 20000;
    localparam int NumRandom = 900;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;

    t_req pending_reqs[$];
    t_rsp expected_quats[$];
    int mismatches = 0;
    int req_count = 0;
    int rsp_count = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit stim_done = 1'b0;
    int case_seen[4] = '{0, 0, 0, 0};
    int invalid_seen = 0;

    rotation_matrix_to_quaternion_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp_word(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (WordBits - 1)) - 1;
        lo = -(longint'(1) <<< (WordBits - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint round_div(longint d, longint s);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : d;
        q = ((mag << FracBits) + s) / (2 * s);
        return clamp_word(d < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_rsp predict_quat(t_req m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint tr;
        longint rad;
        longint s;
        longint q[4];
        logic [1:0] rc;
        t_rsp r;
        a00 = m.e00; a01 = m.e01; a02 = m.e02;
        a10 = m.e10; a11 = m.e11; a12 = m.e12;
        a20 = m.e20; a21 = m.e21; a22 = m.e22;
        q = '{0, 0, 0, 0};
        tr = a00 + a11 + a22;
        if (tr > 0) begin
            rc = CaseTrace;
            rad = tr + (longint'(1) << FracBits);
        end else if (a00 > a11 && a00 > a22) begin
            rc = CaseRootX;
            rad = (longint'(1) << FracBits) + a00 - (a11 + a22);
        end else if (a11 > a22) begin
            rc = CaseRootY;
            rad = (longint'(1) << FracBits) + a11 - (a22 + a00);
        end else begin
            rc = CaseRootZ;
            rad = (longint'(1) << FracBits) + a22 - (a00 + a11);
        end
        r.root_case = rc;
        r.invalid = (rad <= 0);
        if (rad > 0) begin
            s = int_sqrt(longint'(rad) << FracBits);
            if (s == 0) s = 1;
            q[rc] = clamp_word((s + 1) >> 1);
            case (rc)
                CaseTrace: begin
                    q[1] = round_div(a12 - a21, s);
                    q[2] = round_div(a20 - a02, s);
                    q[3] = round_div(a01 - a10, s);
                end
                CaseRootX: begin
                    q[2] = round_div(a01 + a10, s);
                    q[3] = round_div(a02 + a20, s);
                    q[0] = round_div(a12 - a21, s);
                end
                CaseRootY: begin
                    q[3] = round_div(a12 + a21, s);
                    q[1] = round_div(a10 + a01, s);
                    q[0] = round_div(a20 - a02, s);
                end
                default: begin
                    q[1] = round_div(a20 + a02, s);
                    q[2] = round_div(a21 + a12, s);
                    q[0] = round_div(a01 - a10, s);
                end
            endcase
        end
        r.qw = q[0][WordBits-1:0];
        r.qx = q[1][WordBits-1:0];
        r.qy = q[2][WordBits-1:0];
        r.qz = q[3][WordBits-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [WordBits-1:0] rand_entry(int mode);
        case (mode)
            0: return WordBits'($urandom);
            1: return WordBits'($signed($urandom_range(0, 32768)) - 16384);
            default: return WordBits'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic t_req rand_matrix();
        t_req m;
        int mode;
        int k;
        logic [WordBits-1:0] e[9];
        mode = $urandom_range(0, 2);
        for (k = 0; k < 9; k++) e[k] = rand_entry(mode);
        // bias toward each root case
        if (mode != 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, 2) * 4;
            e[k] = WordBits'($urandom_range(8000, 16384));
            e[(k + 4) % 12] = WordBits'(-$signed($urandom_range(4000, 16384)));
            e[(k + 8) % 12] = WordBits'(-$signed($urandom_range(4000, 16384)));
        end
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return m;
    endfunction

    task automatic add_matrix(t_req m);
        pending_reqs.push_back(m);
    endtask

    initial begin
        int n;
        t_req m;
        // identity, all extremes, each root case, ties
        add_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                    16'sd0, 16'sd0, 16'sd16384});
        add_matrix('0);
        add_matrix({9{16'sh7fff}});
        add_matrix({9{16'sh8000}});
        add_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                    16'sd0, 16'sd0, -16'sd16384});
        add_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                    16'sd0, 16'sd0, -16'sd16384});
        add_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                    16'sd0, 16'sd0, 16'sd16384});
        add_matrix({-16'sd8192, 16'sd5, -16'sd7, 16'sd3, -16'sd8192, 16'sd9,
                    -16'sd2, 16'sd4, -16'sd8192});
        add_matrix({16'sd0, 16'sd100, 16'sd0, -16'sd100, -16'sd100, 16'sd0,
                    16'sd0, 16'sd0, -16'sd100});
        add_matrix({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                    16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        add_matrix({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                    16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        add_matrix({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
                    16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000});
        add_matrix({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                    16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        add_matrix({16'sd0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd0, 16'sh7fff,
                    16'sh8000, 16'sh8000, -16'sd1});
        add_matrix({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                    16'sd0, 16'sd0, -16'sd1});
        add_matrix({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                    16'sd0, 16'sd0, -16'sd16384});
        add_matrix({16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                    16'sd0, 16'sd0, 16'sd16384});
        for (n = 0; n < NumRandom; n++) begin
            m = rand_matrix();
            add_matrix(m);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_quats.push_back(predict_quat(i_req));
                req_count <= req_count + 1;
            end
            if ((!i_valid || o_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_req <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_q;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                rsp_count <= rsp_count + 1;
                if (expected_quats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %h", o_rsp);
                end else begin
                    exp_q = expected_quats.pop_front();
                    case_seen[exp_q.root_case]++;
                    if (exp_q.invalid) invalid_seen++;
                    if (o_rsp.qw !== exp_q.qw || o_rsp.qx !== exp_q.qx
                        || o_rsp.qy !== exp_q.qy || o_rsp.qz !== exp_q.qz
                        || o_rsp.root_case !== exp_q.root_case
                        || o_rsp.invalid !== exp_q.invalid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp w%0d x%0d y%0d z%0d c%0d i%0d",
                                      " got w%0d x%0d y%0d z%0d c%0d i%0d"},
                                exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz,
                                exp_q.root_case, exp_q.invalid,
                                o_rsp.qw, o_rsp.qx, o_rsp.qy, o_rsp.qz,
                                o_rsp.root_case, o_rsp.invalid);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int tail;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && expected_quats.size() == 0) && idle_cycles < WatchLimit)
            @(posedge i_clk);
        tail = 0;
        while (tail < 2 * Latency && idle_cycles < WatchLimit) begin
            @(posedge i_clk);
            tail++;
        end
        if (idle_cycles >= WatchLimit) begin
            $display("[rotation_matrix_to_quaternion_top] ERROR");
            $finish;
        end else begin
            $display("Sent %0d matrices, checked %0d quaternions, %0d mismatches.",
                req_count, rsp_count, mismatches);
            $display("Cases trace/x/y/z: %0d/%0d/%0d/%0d, non-positive radicand: %0d",
                case_seen[0], case_seen[1], case_seen[2], case_seen[3], invalid_seen);
            if (mismatches == 0 && expected_quats.size() == 0)
                $display("[rotation_matrix_to_quaternion_top] OK");
            else
                $display("[rotation_matrix_to_quaternion_top] ERROR");
            $finish;
        end
    end
endmodule
